// ===== src/cpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

	localparam int CONTEXTS_DEF   = 4;
	localparam int CLASSES_DEF    = 6;
	localparam int OPERATIONS_DEF = 3;
	localparam int INSTANCES_DEF  = 32;

	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_BIND   = 2'd1,
		OP_UNBIND = 2'd2
	} cpc_op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DENIED  = 2'd1,
		STS_NOSPACE = 2'd2
	} cpc_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_COPY = 1'b1
	} cpc_state_t;

	typedef struct packed {
		logic we;
		logic re;
	} cpc_mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/cpc_grant_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpc_grant_mem #(
	parameter int DEPTH = 72,
	parameter int WIDTH = 32,
	parameter int AW    = 7
) (
	input  wire                 clk,
	input  cpc_pkg::cpc_mem_ctl_t ctl,
	input  wire  [AW-1:0]       waddr,
	input  wire  [WIDTH-1:0]    wdata,
	input  wire  [AW-1:0]       raddr,
	output logic [WIDTH-1:0]    rdata
);
	import cpc_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/context_permission_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake           | payload
// in      | in_valid / in_ready | op app_id perm_class perm_op instance_req grant_bits last_word
// out     | out_valid/ out_ready| status denial_event slot_index
//
// Checks, bind words, unbinds: one beat per cycle unless a copy runs or the output stalls;
// results pass stage 1, then the output register. A committing bind word that finds a free
// slot holds in_ready low; staged words go to the grant memory, one per cycle, on its write port.
// Reset clears slot occupancy and staging; the grant memory needs no clearing.
// A stalled output holds one result in the output register and one in stage 1.

module context_permission_checker #(
	parameter int CONTEXTS   = cpc_pkg::CONTEXTS_DEF,
	parameter int CLASSES    = cpc_pkg::CLASSES_DEF,
	parameter int OPERATIONS = cpc_pkg::OPERATIONS_DEF,
	parameter int INSTANCES  = cpc_pkg::INSTANCES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire  [15:0] app_id,
	input  wire  [2:0]  perm_class,
	input  wire  [1:0]  perm_op,
	input  wire  [7:0]  instance_req,
	input  wire  [31:0] grant_bits,
	input  wire         last_word,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic        denial_event,
	output logic [1:0]  slot_index
);
	import cpc_pkg::*;

	localparam int PAIRS  = CLASSES * OPERATIONS;
	localparam int DEPTH  = CONTEXTS * PAIRS;
	localparam int SLOT_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cpc_state_t state_q, state_d;

	logic                 slot_used_q [CONTEXTS];
	logic [15:0]          slot_app_q  [CONTEXTS];
	logic [INSTANCES-1:0] stg_q       [PAIRS];
	logic                 stg_vld_q   [PAIRS];

	logic [PAIR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] copy_base_q;

	logic              vld_s1;
	logic              mem_s1;
	logic [4:0]        bit_s1;
	logic [1:0]        status_s1;
	logic              event_s1;
	logic [1:0]        slot_s1;

	logic              mem_d;
	logic [1:0]        status_d;
	logic              event_d;
	logic [1:0]        slot_d;

	logic              out_vld_q;
	logic [1:0]        status_q;
	logic              event_q;
	logic [1:0]        slot_q;

	logic              accept;
	logic              s1_adv;
	logic              copy_last;
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;
	logic              free_any;
	logic [SLOT_W-1:0] free_slot;
	logic [5:0]        pair_full;
	logic [PAIR_W-1:0] pair;
	logic              pair_ok;
	logic              inst_ok;
	logic [SLOT_W+1:0] hit_ext;
	logic [SLOT_W+1:0] free_ext;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [INSTANCES-1:0] wdata;
	logic [INSTANCES-1:0] rdata;
	logic [31:0]       rword;
	logic              granted;
	cpc_mem_ctl_t      mem_ctl;

	assign s1_adv    = vld_s1 && (!out_vld_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign copy_last = (cnt_q == PAIR_W'(PAIRS - 1));

	assign pair_full = 6'(perm_class) * 6'(OPERATIONS) + 6'(perm_op);
	assign pair      = pair_full[PAIR_W-1:0];
	assign pair_ok   = (32'(perm_class) < CLASSES) && (32'(perm_op) < OPERATIONS);
	assign inst_ok   = 32'(instance_req) < INSTANCES;

	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		free_any = 1'b0;
		free_slot = '0;
		for (int s = CONTEXTS - 1; s >= 0; s--) begin
			if (slot_used_q[s] && slot_app_q[s] == app_id) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(s);
			end
			if (!slot_used_q[s]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
	end

	assign hit_ext  = {2'b00, hit_slot};
	assign free_ext = {2'b00, free_slot};

	assign raddr = ADDR_W'(hit_slot) * ADDR_W'(PAIRS) + ADDR_W'(pair);
	assign waddr = copy_base_q + ADDR_W'(cnt_q);
	assign wdata = stg_vld_q[cnt_q] ? stg_q[cnt_q] : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cpc_op_t'(op) == OP_BIND && last_word && free_any) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (copy_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		mem_ctl.we = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !vld_s1 || s1_adv;
			ST_COPY: mem_ctl.we = 1'b1;
			default: in_ready = 1'b0;
		endcase
		mem_ctl.re = accept && cpc_op_t'(op) == OP_CHECK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COPY) begin
				cnt_q <= copy_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < CONTEXTS; s++) begin
				slot_used_q[s] <= 1'b0;
			end
			for (int p = 0; p < PAIRS; p++) begin
				stg_vld_q[p] <= 1'b0;
			end
		end else begin
			if (state_q == ST_COPY && copy_last) begin
				for (int p = 0; p < PAIRS; p++) begin
					stg_vld_q[p] <= 1'b0;
				end
			end
			if (accept) begin
				case (cpc_op_t'(op))
					OP_BIND: begin
						if (last_word) begin
							if (free_any) begin
								slot_used_q[free_slot] <= 1'b1;
							end else begin
								for (int p = 0; p < PAIRS; p++) begin
									stg_vld_q[p] <= 1'b0;
								end
							end
						end
						if (pair_ok && !(last_word && !free_any)) begin
							stg_vld_q[pair] <= 1'b1;
						end
					end
					OP_UNBIND: begin
						if (hit) begin
							slot_used_q[hit_slot] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload stores, no reset
	always_ff @(posedge clk) begin
		if (accept && cpc_op_t'(op) == OP_BIND) begin
			if (pair_ok) begin
				stg_q[pair] <= grant_bits[INSTANCES-1:0];
			end
			if (last_word && free_any) begin
				slot_app_q[free_slot] <= app_id;
				copy_base_q <= ADDR_W'(free_slot) * ADDR_W'(PAIRS);
			end
		end
	end

	cpc_grant_mem #(
		.DEPTH (DEPTH),
		.WIDTH (INSTANCES),
		.AW    (ADDR_W)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_comb begin
		mem_d    = 1'b0;
		status_d = STS_OK;
		event_d  = 1'b0;
		slot_d   = 2'b00;
		case (cpc_op_t'(op))
			OP_CHECK: begin
				if (!hit) begin
					status_d = STS_DENIED;
				end else begin
					slot_d = hit_ext[1:0];
					if (pair_ok && inst_ok) begin
						mem_d = 1'b1;
					end else begin
						status_d = STS_DENIED;
						event_d  = 1'b1;
					end
				end
			end
			OP_BIND: begin
				if (last_word) begin
					if (free_any) begin
						slot_d = free_ext[1:0];
					end else begin
						status_d = STS_NOSPACE;
					end
				end
			end
			OP_UNBIND: begin
				if (hit) begin
					slot_d = hit_ext[1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_s1    <= mem_d;
			bit_s1    <= instance_req[4:0];
			status_s1 <= status_d;
			event_s1  <= event_d;
			slot_s1   <= slot_d;
		end
	end

	assign rword   = 32'(rdata);
	assign granted = rword[bit_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			slot_q <= slot_s1;
			if (mem_s1) begin
				status_q <= granted ? STS_OK : STS_DENIED;
				event_q  <= !granted;
			end else begin
				status_q <= status_s1;
				event_q  <= event_s1;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign denial_event = event_q;
	assign slot_index   = slot_q;

`ifndef NO_ASSERTIONS
	a_copy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> !in_ready)
		else $error("beat accepted during staging copy");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_adv |=> vld_s1)
		else $error("stage 1 result dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STS_OK || status == STS_DENIED || status == STS_NOSPACE))
		else $error("illegal status code");

	a_event_denied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && denial_event |-> status == STS_DENIED)
		else $error("denial event without denial");

	a_copy_enter: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_COPY) |-> cnt_q == '0 && $past(accept))
		else $error("copy entered without commit beat");
`endif

endmodule

`default_nettype wire

// ===== verif/context_permission_checker_tb.sv =====
`timescale 1ns / 1ps

module context_permission_checker_tb;
	import cpc_pkg::*;

	localparam int NCTX = CONTEXTS_DEF;
	localparam int NCLS = CLASSES_DEF;
	localparam int NOPS = OPERATIONS_DEF;
	localparam int NINST = INSTANCES_DEF;
	localparam int PAIRS = NCLS * NOPS;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
		logic [2:0]  cls;
		logic [1:0]  pop;
		logic [7:0]  inst;
		logic [31:0] bits;
		logic        last_w;
	} access_req_t;

	typedef struct packed {
		cpc_status_t status;
		logic        denial;
		logic [1:0]  slot;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [15:0] app_id = '0;
	logic [2:0]  perm_class = '0;
	logic [1:0]  perm_op = '0;
	logic [7:0]  instance_req = '0;
	logic [31:0] grant_bits = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        denial_event;
	logic [1:0]  slot_index;

	// shadow of the context table
	logic        ctx_used [NCTX];
	logic [15:0] ctx_app [NCTX];
	logic [31:0] ctx_grants [NCTX][PAIRS];
	logic [31:0] staged_grants [PAIRS];

	verdict_t    expected_verdicts [$];
	logic [15:0] id_pool [8];
	int          errors = 0;
	int          sent_items = 0;
	int          stall_cnt = 0;
	int          hold_len = 0;
	int          stall_left = 0;
	bit          send_gaps = 1'b1;
	bit          ready_gaps = 1'b1;

	context_permission_checker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.app_id(app_id),
		.perm_class(perm_class),
		.perm_op(perm_op),
		.instance_req(instance_req),
		.grant_bits(grant_bits),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.denial_event(denial_event),
		.slot_index(slot_index)
	);

	always #2 clk = ~clk;

	function automatic verdict_t predict_verdict(input access_req_t rq);
		verdict_t v;
		int hit;
		int free_slot;
		int pair;
		logic pair_ok;
		v.status = STS_OK;
		v.denial = 1'b0;
		v.slot = 2'd0;
		hit = -1;
		free_slot = -1;
		pair_ok = (rq.cls < NCLS) && (rq.pop < NOPS);
		pair = rq.cls * NOPS + rq.pop;
		for (int s = NCTX - 1; s >= 0; s--) begin
			if (ctx_used[s] && ctx_app[s] == rq.id)
				hit = s;
			if (!ctx_used[s])
				free_slot = s;
		end
		case (rq.op)
			OP_CHECK: begin
				if (hit < 0) begin
					v.status = STS_DENIED;
				end else begin
					v.slot = 2'(hit);
					if (pair_ok && rq.inst < NINST && ctx_grants[hit][pair][rq.inst[4:0]]) begin
						v.status = STS_OK;
					end else begin
						v.status = STS_DENIED;
						v.denial = 1'b1;
					end
				end
			end
			OP_BIND: begin
				if (pair_ok)
					staged_grants[pair] = rq.bits;
				if (rq.last_w) begin
					if (free_slot >= 0) begin
						ctx_used[free_slot] = 1'b1;
						ctx_app[free_slot] = rq.id;
						for (int k = 0; k < PAIRS; k++)
							ctx_grants[free_slot][k] = staged_grants[k];
						v.slot = 2'(free_slot);
					end else begin
						v.status = STS_NOSPACE;
					end
					for (int k = 0; k < PAIRS; k++)
						staged_grants[k] = '0;
				end
			end
			OP_UNBIND: begin
				if (hit >= 0) begin
					ctx_used[hit] = 1'b0;
					v.slot = 2'(hit);
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 2);
		if (p < 96)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic access_req_t mk(input logic [1:0] o, input logic [15:0] id,
			input logic [2:0] cls, input logic [1:0] pop, input logic [7:0] inst,
			input logic [31:0] bits, input logic lw);
		access_req_t rq;
		rq.op = o;
		rq.id = id;
		rq.cls = cls;
		rq.pop = pop;
		rq.inst = inst;
		rq.bits = bits;
		rq.last_w = lw;
		return rq;
	endfunction

	function automatic access_req_t rand_req();
		return mk(2'($urandom_range(0, 3)), 16'($urandom), 3'($urandom), 2'($urandom),
			8'($urandom), $urandom, 1'($urandom));
	endfunction

	task automatic send_beat(input access_req_t rq);
		int gap;
		gap = send_gaps ? gap_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= rq.op;
		app_id <= rq.id;
		perm_class <= rq.cls;
		perm_op <= rq.pop;
		instance_req <= rq.inst;
		grant_bits <= rq.bits;
		last_word <= rq.last_w;
		do @(posedge clk); while (!in_ready);
		expected_verdicts.push_back(predict_verdict(rq));
		if (rq.op != OP_SPARE)
			sent_items++;
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t unexpected beat: status %0d denial %0b slot %0d",
					$time, status, denial_event, slot_index);
				errors++;
			end else begin
				v = expected_verdicts.pop_front();
				if (status !== v.status) begin
					$display("%0t status expected %0d actual %0d", $time, v.status, status);
					errors++;
				end
				if (denial_event !== v.denial) begin
					$display("%0t denial_event expected %0b actual %0b",
						$time, v.denial, denial_event);
					errors++;
				end
				if (slot_index !== v.slot) begin
					$display("%0t slot_index expected %0d actual %0d",
						$time, v.slot, slot_index);
					errors++;
				end
			end
		end
	end

	// receiver
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (!ready_gaps) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			stall_cnt <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
	end

	initial begin
		while (stall_cnt < STALL_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	task automatic test_empty_table();
		send_beat(mk(OP_CHECK, 16'h0000, 3'd0, 2'd0, 8'd0, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd5, 2'd2, 8'd31, 32'hFFFFFFFF, 1'b1));
	endtask

	task automatic test_bind_and_lookup();
		send_beat(mk(OP_BIND, 16'h0000, 3'd0, 2'd0, 8'd0, 32'h00000001, 1'b0));
		send_beat(mk(OP_BIND, 16'h0000, 3'd5, 2'd2, 8'd0, 32'h80000000, 1'b0));
		send_beat(mk(OP_BIND, 16'h0000, 3'd6, 2'd0, 8'd0, 32'hFFFFFFFF, 1'b0));
		send_beat(mk(OP_BIND, 16'h0000, 3'd7, 2'd3, 8'd0, 32'hFFFFFFFF, 1'b0));
		send_beat(mk(OP_BIND, 16'h0000, 3'd1, 2'd3, 8'd0, 32'hFFFFFFFF, 1'b0));
		send_beat(mk(OP_BIND, 16'hFFFF, 3'd3, 2'd1, 8'd0, 32'hAAAAAAAA, 1'b1));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd0, 2'd0, 8'd0, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd5, 2'd2, 8'd31, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd0, 2'd0, 8'd32, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd0, 2'd0, 8'd255, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd6, 2'd0, 8'd0, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd3, 2'd3, 8'd1, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd3, 2'd1, 8'd0, 32'h0, 1'b0));
		send_beat(mk(OP_CHECK, 16'hFFFF, 3'd3, 2'd1, 8'd1, 32'h0, 1'b0));
	endtask

	task automatic test_spare_and_unbind_miss();
		send_beat(mk(OP_SPARE, 16'hFFFF, 3'd7, 2'd3, 8'd255, 32'hFFFFFFFF, 1'b1));
		send_beat(mk(OP_UNBIND, 16'h0000, 3'd0, 2'd0, 8'd0, 32'h0, 1'b0));
	endtask

	task automatic test_table_full();
		send_beat(mk(OP_BIND, 16'h1234, 3'd2, 2'd1, 8'd0, 32'h5555AAAA, 1'b1));
		send_beat(mk(OP_BIND, 16'h1234, 3'd2, 2'd1, 8'd0, 32'h0000FFFF, 1'b1));
		send_beat(mk(OP_BIND, 16'h0001, 3'd4, 2'd0, 8'd0, 32'hFFFF0000, 1'b1));
		send_beat(mk(OP_BIND, 16'h8000, 3'd1, 2'd1, 8'd0, 32'hFFFFFFFF, 1'b1));
		send_beat(mk(OP_CHECK, 16'h1234, 3'd2, 2'd1, 8'd1, 32'h0, 1'b0));
		send_beat(mk(OP_UNBIND, 16'hFFFF, 3'd0, 2'd0, 8'd0, 32'h0, 1'b0));
		send_beat(mk(OP_BIND, 16'h8000, 3'd0, 2'd0, 8'd0, 32'h00000000, 1'b1));
	endtask

	task automatic test_backpressure();
		access_req_t rq;
		send_gaps = 1'b0;
		hold_len = HOLD_CYCLES;
		for (int i = 0; i < 30; i++) begin
			rq = rand_req();
			rq.op = OP_CHECK;
			rq.id = ctx_app[$urandom_range(0, NCTX - 1)];
			rq.cls = 3'($urandom_range(0, NCLS - 1));
			rq.pop = 2'($urandom_range(0, NOPS - 1));
			rq.inst = 8'($urandom_range(0, NINST - 1));
			send_beat(rq);
		end
		send_gaps = 1'b1;
	endtask

	function automatic logic [15:0] pick_id();
		int s;
		s = $urandom_range(0, NCTX - 1);
		if (ctx_used[s] && $urandom_range(0, 9) < 7)
			return ctx_app[s];
		return id_pool[$urandom_range(0, 7)];
	endfunction

	task automatic send_bind_sequence();
		access_req_t rq;
		int words;
		int used_cnt;
		used_cnt = 0;
		for (int s = 0; s < NCTX; s++)
			used_cnt += ctx_used[s];
		if (used_cnt >= NCTX - 1 && $urandom_range(0, 1) == 0) begin
			rq = rand_req();
			rq.op = OP_UNBIND;
			rq.id = ctx_app[$urandom_range(0, NCTX - 1)];
			send_beat(rq);
		end
		words = ($urandom_range(0, 9) == 0) ? PAIRS : $urandom_range(0, 5);
		for (int w = 0; w <= words; w++) begin
			rq = rand_req();
			rq.op = OP_BIND;
			rq.last_w = (w == words);
			if (words == PAIRS && w < PAIRS) begin
				rq.cls = 3'(w / NOPS);
				rq.pop = 2'(w % NOPS);
			end else begin
				rq.cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NCLS, 7))
					: 3'($urandom_range(0, NCLS - 1));
				rq.pop = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(NOPS, 3))
					: 2'($urandom_range(0, NOPS - 1));
			end
			case ($urandom_range(0, 7))
				0: rq.bits = '0;
				1: rq.bits = '1;
				default: rq.bits = $urandom;
			endcase
			if (rq.last_w)
				rq.id = id_pool[$urandom_range(0, 7)];
			send_beat(rq);
		end
	endtask

	task automatic test_random_traffic(input int n);
		access_req_t rq;
		int goal;
		int p;
		goal = sent_items + n;
		while (sent_items < goal) begin
			if ($urandom_range(0, 49) == 0)
				id_pool[$urandom_range(2, 7)] = 16'($urandom);
			p = $urandom_range(0, 99);
			rq = rand_req();
			if (p < 25) begin
				send_bind_sequence();
			end else begin
				if (p < 37) begin
					rq.op = OP_UNBIND;
					rq.id = pick_id();
				end else if (p < 95) begin
					rq.op = OP_CHECK;
					rq.id = pick_id();
					if ($urandom_range(0, 9) != 0) begin
						rq.cls = 3'($urandom_range(0, NCLS - 1));
						rq.pop = 2'($urandom_range(0, NOPS - 1));
					end
					if ($urandom_range(0, 6) != 0)
						rq.inst = 8'($urandom_range(0, NINST - 1));
				end else if (p < 97) begin
					rq.op = OP_SPARE;
				end
				send_beat(rq);
			end
		end
	endtask

	initial begin
		for (int s = 0; s < NCTX; s++) begin
			ctx_used[s] = 1'b0;
			ctx_app[s] = '0;
			for (int k = 0; k < PAIRS; k++)
				ctx_grants[s][k] = '0;
		end
		for (int k = 0; k < PAIRS; k++)
			staged_grants[k] = '0;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			id_pool[i] = 16'($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_table();
		test_bind_and_lookup();
		test_spare_and_unbind_miss();
		test_table_full();
		test_backpressure();
		test_random_traffic(300);
		send_gaps = 1'b0;
		ready_gaps = 1'b0;
		test_random_traffic(250);
		send_gaps = 1'b1;
		ready_gaps = 1'b1;
		test_random_traffic(300);
		send_gaps = 1'b0;
		test_random_traffic(150);
		send_gaps = 1'b1;
		ready_gaps = 1'b0;
		test_random_traffic(150);
		in_valid <= 1'b0;

		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== context_permission_checker.f =====
src/cpc_pkg.sv
src/cpc_grant_mem.sv
src/context_permission_checker.sv
verif/context_permission_checker_tb.sv
